// File: hdl/ecss_pkg.sv
// Shared types and constants for the entity component sparse set block.
// Used by the controller, datapath and top level; no dependencies.
package ecss_pkg;

   localparam int MAX_ENTITIES_DEF = 256;
   localparam int NUM_TYPES_DEF    = 4;
   localparam int DATA_WIDTH_DEF   = 32;

   localparam int CMD_W    = 3;
   localparam int ENTITY_W = 8;
   localparam int TYPE_W   = 2;
   localparam int DIN_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;

   typedef enum logic [2:0] {
      CMD_CREATE  = 3'd0,
      CMD_DESTROY = 3'd1,
      CMD_ATTACH  = 3'd2,
      CMD_DETACH  = 3'd3,
      CMD_QUERY   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ENT   = 3'd1,
      ST_DISABLED  = 3'd2,
      ST_NOT_ATT   = 3'd3,
      ST_EXHAUSTED = 3'd4,
      ST_DUPLICATE = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_SPARSE,
      FSM_DENSE,
      FSM_CHECK,
      FSM_LASTRD,
      FSM_LASTWAIT,
      FSM_MOVE,
      FSM_NEXTTYPE,
      FSM_RESP
   } fsm_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;        // capture the request fields
      logic do_create;   // perform create (free stack or fresh id)
      logic do_free;     // clear live bit and push id
      logic rd_sparse;   // read sparse index of (cur type, entity)
      logic rd_dense;    // read dense entry at the sparse index
      logic rd_last;     // read dense entry at count - 1
      logic do_append;   // attach writes
      logic do_move;     // move last into the hole, fix sparse index
      logic do_shrink;   // decrement member count of cur type
      logic set_status;  // load status from stat_code
      logic [2:0] stat_code;
      logic cap_data;    // capture query data
      logic first_type;  // cur type = 0
      logic next_type;   // cur type + 1
      logic use_req_type;// cur type = request type
      logic resp;        // present the response
   } ctl_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       ent_ok;
      logic       type_ok;
      logic       member;
      logic       count_zero;
      logic       count_full;
      logic       idx_is_last;
      logic       last_type;
      logic       resp_busy;
   } sts_type;

endpackage

// File: hdl/ecss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ecss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hdl/ecss_ctrl.sv
// Command sequencer for the entity component sparse set block.
// Depends on ecss_pkg; drives the datapath through ctl_type commands.
module ecss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ecss_pkg::sts_type  sts,
   output ecss_pkg::ctl_type  ctl
);
   ecss_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecss_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ecss_pkg::FSM_IDLE: begin
            req_tready = !sts.resp_busy;
            if (req_tvalid && !sts.resp_busy) begin
               ctl.load = 1'b1;
               state_in = ecss_pkg::FSM_DECODE;
            end
         end
         ecss_pkg::FSM_DECODE: begin
            state_in = ecss_pkg::FSM_RESP;
            if (sts.cmd == ecss_pkg::CMD_CREATE) begin
               ctl.do_create = 1'b1;
            end else if (sts.cmd inside {ecss_pkg::CMD_DESTROY, ecss_pkg::CMD_ATTACH,
                                         ecss_pkg::CMD_DETACH, ecss_pkg::CMD_QUERY}) begin
               if (!sts.ent_ok) begin
                  ctl.set_status = 1'b1;
                  ctl.stat_code  = ecss_pkg::ST_BAD_ENT;
               end else if (sts.cmd == ecss_pkg::CMD_DESTROY) begin
                  ctl.do_free    = 1'b1;
                  ctl.first_type = 1'b1;
                  state_in       = ecss_pkg::FSM_SPARSE;
               end else if (!sts.type_ok) begin
                  ctl.set_status = 1'b1;
                  ctl.stat_code  = ecss_pkg::ST_DISABLED;
               end else begin
                  ctl.use_req_type = 1'b1;
                  state_in         = ecss_pkg::FSM_SPARSE;
               end
            end
         end
         ecss_pkg::FSM_SPARSE: begin
            ctl.rd_sparse = 1'b1;
            state_in      = ecss_pkg::FSM_DENSE;
         end
         ecss_pkg::FSM_DENSE: begin
            ctl.rd_dense = 1'b1;
            state_in     = ecss_pkg::FSM_CHECK;
         end
         ecss_pkg::FSM_CHECK: begin
            state_in = ecss_pkg::FSM_RESP;
            case (sts.cmd)
               ecss_pkg::CMD_ATTACH: begin
                  if (sts.member) begin
                     ctl.set_status = 1'b1;
                     ctl.stat_code  = ecss_pkg::ST_DUPLICATE;
                  end else if (!sts.count_full) begin
                     ctl.do_append = 1'b1;
                  end
               end
               ecss_pkg::CMD_DETACH: begin
                  if (sts.count_zero) begin
                     state_in = ecss_pkg::FSM_RESP;
                  end else if (!sts.member) begin
                     ctl.set_status = 1'b1;
                     ctl.stat_code  = ecss_pkg::ST_NOT_ATT;
                  end else if (sts.idx_is_last) begin
                     ctl.do_shrink = 1'b1;
                  end else begin
                     state_in = ecss_pkg::FSM_LASTRD;
                  end
               end
               ecss_pkg::CMD_QUERY: begin
                  if (!sts.member) begin
                     ctl.set_status = 1'b1;
                     ctl.stat_code  = ecss_pkg::ST_NOT_ATT;
                  end else begin
                     ctl.cap_data = 1'b1;
                  end
               end
               default: begin
                  // Destroy walks every type.
                  if (sts.member && sts.idx_is_last) begin
                     ctl.do_shrink = 1'b1;
                     state_in      = ecss_pkg::FSM_NEXTTYPE;
                  end else if (sts.member) begin
                     state_in = ecss_pkg::FSM_LASTRD;
                  end else begin
                     state_in = ecss_pkg::FSM_NEXTTYPE;
                  end
               end
            endcase
         end
         ecss_pkg::FSM_LASTRD: begin
            ctl.rd_last = 1'b1;
            state_in    = ecss_pkg::FSM_LASTWAIT;
         end
         ecss_pkg::FSM_LASTWAIT: begin
            state_in = ecss_pkg::FSM_MOVE;
         end
         ecss_pkg::FSM_MOVE: begin
            ctl.do_move   = 1'b1;
            ctl.do_shrink = 1'b1;
            state_in = (sts.cmd == ecss_pkg::CMD_DESTROY) ? ecss_pkg::FSM_NEXTTYPE
                                                          : ecss_pkg::FSM_RESP;
         end
         ecss_pkg::FSM_NEXTTYPE: begin
            if (sts.last_type) begin
               ctl.use_req_type = 1'b1;
               state_in         = ecss_pkg::FSM_RESP;
            end else begin
               ctl.next_type = 1'b1;
               state_in      = ecss_pkg::FSM_SPARSE;
            end
         end
         ecss_pkg::FSM_RESP: begin
            ctl.resp = 1'b1;
            state_in = ecss_pkg::FSM_IDLE;
         end
         default: begin
            state_in = ecss_pkg::FSM_IDLE;
         end
      endcase
   end
endmodule

// File: hdl/ecss_dpath.sv
// Datapath: request registers, allocator, live bits, counts and set memories.
// Depends on ecss_pkg and ecss_ram.
module ecss_dpath #(
   parameter int MAX_ENTITIES = ecss_pkg::MAX_ENTITIES_DEF,
   parameter int NUM_TYPES    = ecss_pkg::NUM_TYPES_DEF,
   parameter int DATA_WIDTH   = ecss_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ecss_pkg::CMD_W-1:0]         req_cmd,
   input  logic [ecss_pkg::ENTITY_W-1:0]      req_entity,
   input  logic [ecss_pkg::TYPE_W-1:0]        req_type,
   input  logic [ecss_pkg::DIN_W-1:0]         req_data,
   input  logic                               csr_we,
   input  logic [NUM_TYPES-1:0]               csr_data,
   input  ecss_pkg::ctl_type                  ctl,
   output ecss_pkg::sts_type                  sts,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ecss_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ecss_pkg::ENTITY_W-1:0]      rsp_entity,
   output logic [ecss_pkg::DIN_W-1:0]         rsp_data,
   output logic [ecss_pkg::COUNT_W-1:0]       rsp_count
);
   localparam int EW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
   localparam int CW = $clog2(MAX_ENTITIES + 1);
   localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int SLOTS = MAX_ENTITIES * NUM_TYPES;
   localparam int SW = $clog2(SLOTS);

   logic [ecss_pkg::CMD_W-1:0]    cmd_ff;
   logic [ecss_pkg::ENTITY_W-1:0] ent_ff;
   logic [ecss_pkg::TYPE_W-1:0]   rtype_ff;
   logic [DATA_WIDTH-1:0]         din_ff;
   logic [TW-1:0]                 cur_ff;
   logic [NUM_TYPES-1:0]          enable_ff;
   logic [CW-1:0]                 fresh_ff, top_ff;
   logic [MAX_ENTITIES-1:0]       live_ff;
   logic [CW-1:0]                 count_ff [NUM_TYPES];
   logic [ecss_pkg::STATUS_W-1:0] status_ff;
   logic [ecss_pkg::ENTITY_W-1:0] eout_ff;
   logic [DATA_WIDTH-1:0]         qdata_ff;
   logic                          rvalid_ff;
   logic [ecss_pkg::STATUS_W-1:0] ostat_ff;
   logic [ecss_pkg::ENTITY_W-1:0] oent_ff;
   logic [ecss_pkg::DIN_W-1:0]    odata_ff;
   logic [ecss_pkg::COUNT_W-1:0]  ocount_ff;
   logic [EW-1:0]                 idx_ff;     // sparse index of the entity
   logic [EW-1:0]                 moved_ff;   // entity moved from the last slot
   logic [DATA_WIDTH-1:0]         mdata_ff;

   logic [EW-1:0]         ent_e;
   logic [CW-1:0]         cnt_cur, last;
   logic [EW-1:0]         last_e;
   logic                  ent_in_range;
   logic [EW-1:0]         fs_rd, sp_rd, de_rd;
   logic [DATA_WIDTH-1:0] dd_rd;
   logic                  fs_we, sp_we, de_we, dd_we;
   logic [EW-1:0]         fs_waddr, fs_wdata, sp_wdata, de_wdata, fs_raddr;
   logic [SW-1:0]         sp_waddr, sp_raddr, de_waddr, de_raddr;
   logic [DATA_WIDTH-1:0] dd_wdata;
   logic                  rd_last_d;

   assign ent_e        = EW'(ent_ff);
   assign ent_in_range = (32'(ent_ff) < 32'(MAX_ENTITIES));
   assign cnt_cur      = count_ff[cur_ff];
   assign last         = cnt_cur - CW'(1);
   assign last_e       = last[EW-1:0];

   function automatic logic [SW-1:0] slot(input logic [TW-1:0] t, input logic [EW-1:0] i);
      slot = SW'((32'(t) * MAX_ENTITIES) + 32'(i));
   endfunction

   // Free stack: prefetch the top entry so create finishes in one step.
   assign fs_raddr = EW'(top_ff - CW'(1));
   assign fs_we    = ctl.do_free && (32'(top_ff) < 32'(MAX_ENTITIES));
   assign fs_waddr = top_ff[EW-1:0];
   assign fs_wdata = ent_e;

   ecss_ram #(.WIDTH(EW), .DEPTH(MAX_ENTITIES)) u_free (
      .clock, .wr_en(fs_we), .wr_addr(fs_waddr), .wr_data(fs_wdata),
      .rd_addr(fs_raddr), .rd_data(fs_rd));

   assign sp_raddr = slot(cur_ff, ent_e);
   assign sp_we    = ctl.do_append || ctl.do_move;
   assign sp_waddr = ctl.do_move ? slot(cur_ff, moved_ff) : slot(cur_ff, ent_e);
   assign sp_wdata = ctl.do_move ? idx_ff : cnt_cur[EW-1:0];

   ecss_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_sparse (
      .clock, .wr_en(sp_we), .wr_addr(sp_waddr), .wr_data(sp_wdata),
      .rd_addr(sp_raddr), .rd_data(sp_rd));

   assign de_raddr = ctl.rd_last ? slot(cur_ff, last_e) : slot(cur_ff, sp_rd);
   assign de_we    = ctl.do_append || ctl.do_move;
   assign de_waddr = ctl.do_move ? slot(cur_ff, idx_ff) : slot(cur_ff, cnt_cur[EW-1:0]);
   assign de_wdata = ctl.do_move ? moved_ff : ent_e;
   assign dd_we    = de_we;
   assign dd_wdata = ctl.do_move ? mdata_ff : din_ff;

   ecss_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_dent (
      .clock, .wr_en(de_we), .wr_addr(de_waddr), .wr_data(de_wdata),
      .rd_addr(de_raddr), .rd_data(de_rd));

   ecss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_ddata (
      .clock, .wr_en(dd_we), .wr_addr(de_waddr), .wr_data(dd_wdata),
      .rd_addr(de_raddr), .rd_data(dd_rd));

   always_comb begin
      sts             = '0;
      sts.cmd         = cmd_ff;
      sts.ent_ok      = ent_in_range && live_ff[ent_e];
      sts.type_ok     = (32'(rtype_ff) < 32'(NUM_TYPES)) && enable_ff[TW'(rtype_ff)];
      sts.member      = (CW'(idx_ff) < cnt_cur) && (de_rd == ent_e);
      sts.count_zero  = (cnt_cur == '0);
      sts.count_full  = (32'(cnt_cur) >= 32'(MAX_ENTITIES));
      sts.idx_is_last = (CW'(idx_ff) == last);
      sts.last_type   = (32'(cur_ff) == NUM_TYPES - 1);
      sts.resp_busy   = rvalid_ff;
   end

   always_ff @(posedge clock) begin
      rd_last_d  <= ctl.rd_last;
      if (ctl.load) begin
         cmd_ff    <= req_cmd;
         ent_ff    <= req_entity;
         rtype_ff  <= req_type;
         din_ff    <= DATA_WIDTH'(req_data);
         status_ff <= ecss_pkg::ST_OK;
         eout_ff   <= req_entity;
         qdata_ff  <= '0;
      end
      if (ctl.rd_dense) begin
         idx_ff <= sp_rd;
      end
      if (rd_last_d) begin
         moved_ff <= de_rd;
         mdata_ff <= dd_rd;
      end
      if (ctl.set_status) begin
         status_ff <= ctl.stat_code;
      end
      if (ctl.cap_data) begin
         qdata_ff <= dd_rd;
      end
      if (ctl.first_type) begin
         cur_ff <= '0;
      end else if (ctl.next_type) begin
         cur_ff <= cur_ff + TW'(1);
      end else if (ctl.use_req_type) begin
         cur_ff <= TW'(rtype_ff);
      end
      if (ctl.do_create) begin
         if (top_ff != '0) begin
            eout_ff <= ecss_pkg::ENTITY_W'(fs_rd);
         end else if (32'(fresh_ff) < 32'(MAX_ENTITIES)) begin
            eout_ff <= ecss_pkg::ENTITY_W'(fresh_ff);
         end else begin
            status_ff <= ecss_pkg::ST_EXHAUSTED;
         end
      end
      if (ctl.resp) begin
         ostat_ff  <= status_ff;
         oent_ff   <= eout_ff;
         odata_ff  <= ecss_pkg::DIN_W'(qdata_ff);
         ocount_ff <= (32'(rtype_ff) < 32'(NUM_TYPES))
                      ? ecss_pkg::COUNT_W'(count_ff[TW'(rtype_ff)]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         fresh_ff  <= '0;
         top_ff    <= '0;
         live_ff   <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            enable_ff <= csr_data;
            for (int i = 0; i < NUM_TYPES; i++) begin
               count_ff[i] <= '0;
            end
         end
         if (ctl.do_create) begin
            if (top_ff != '0) begin
               top_ff          <= top_ff - CW'(1);
               live_ff[fs_rd]  <= 1'b1;
            end else if (32'(fresh_ff) < 32'(MAX_ENTITIES)) begin
               fresh_ff                 <= fresh_ff + CW'(1);
               live_ff[fresh_ff[EW-1:0]] <= 1'b1;
            end
         end
         if (ctl.do_free) begin
            live_ff[ent_e] <= 1'b0;
            if (32'(top_ff) < 32'(MAX_ENTITIES)) begin
               top_ff <= top_ff + CW'(1);
            end
         end
         if (ctl.do_append) begin
            count_ff[cur_ff] <= cnt_cur + CW'(1);
         end
         if (ctl.do_shrink) begin
            count_ff[cur_ff] <= last;
         end
         if (ctl.resp) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_status = ostat_ff;
   assign rsp_entity = oent_ff;
   assign rsp_data   = odata_ff;
   assign rsp_count  = ocount_ff;
endmodule

// File: hdl/entity_component_sparse_sets.sv
// Entity allocator with one swap-remove sparse set per component type.
// Request tdata (low bit up): cmd[2:0], entity[10:3], component_type[12:11],
// data_in[44:13], zero fill to 48 bits. Response tdata: status[2:0],
// entity_out[10:3], data_out[42:11], type_count[51:43], zero fill to 56 bits.
// A request is taken when req_tvalid and req_tready are high; one response
// follows for every request. Create, an unknown command, and a command
// rejected for a bad entity or a disabled type go from decode straight to the
// response. Attach, query and detach read the sparse then the dense RAM, and
// destroy does so per type; detach and destroy may move the last slot.
// One request is in work at a time; the next is taken once the previous
// response register has drained; each request is finished before the next.
// A stalled rsp_tready holds the response and blocks new requests. The csr
// channel writes type_enable and empties all sets; write it only while idle.
// Synchronous reset clears live bits, counts, the allocator and enables; RAM
// contents are left as they were, and no clearing pass is needed.
module entity_component_sparse_sets #(
   parameter int MAX_ENTITIES = ecss_pkg::MAX_ENTITIES_DEF,
   parameter int NUM_TYPES    = ecss_pkg::NUM_TYPES_DEF,
   parameter int DATA_WIDTH   = ecss_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd, entity, component_type, data_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // status, entity_out, data_out, type_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   ecss_pkg::ctl_type ctl;
   ecss_pkg::sts_type sts;
   logic [ecss_pkg::STATUS_W-1:0] st;
   logic [ecss_pkg::ENTITY_W-1:0] eo;
   logic [ecss_pkg::DIN_W-1:0]    dout;
   logic [ecss_pkg::COUNT_W-1:0]  cnt;
   logic [NUM_TYPES-1:0]          en;

   assign csr_ready = 1'b1;
   always_comb begin
      en = '0;
      for (int i = 0; i < NUM_TYPES && i < 4; i++) begin
         en[i] = csr_data[i];
      end
   end

   ecss_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .sts, .ctl);

   ecss_dpath #(.MAX_ENTITIES(MAX_ENTITIES), .NUM_TYPES(NUM_TYPES),
                .DATA_WIDTH(DATA_WIDTH)) u_dpath (
      .clock, .reset,
      .req_cmd(req_tdata[2:0]), .req_entity(req_tdata[10:3]),
      .req_type(req_tdata[12:11]), .req_data(req_tdata[44:13]),
      .csr_we(csr_valid), .csr_data(en), .ctl, .sts,
      .rsp_tvalid, .rsp_tready,
      .rsp_status(st), .rsp_entity(eo), .rsp_data(dout), .rsp_count(cnt));

   assign rsp_tdata = {4'd0, cnt, dout, eo, st};
endmodule

// File: bench/entity_component_sparse_sets_test.sv
`timescale 1ns / 100ps
// Self-checking bench for entity_component_sparse_sets: directed table, then random commands.
// Needs ecss_pkg and the block; responses are compared against a behavioral sparse-set predictor.
module entity_component_sparse_sets_test;

   localparam int NENT = 256;
   localparam int NTYP = 4;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  ctype;
      logic [7:0]  entity;
      logic [2:0]  cmd;
   } request_type;

   typedef struct packed {
      logic [8:0]  count;
      logic [31:0] data;
      logic [7:0]  entity;
      logic [2:0]  status;
   } response_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [7:0]  entity;
      logic [1:0]  ctype;
      logic [31:0] data;
      bit          typed;
      response_type rsp;
   } directed_row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [3:0] csr_data = '0;

   entity_component_sparse_sets dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state.
   logic [3:0]  enables;
   int unsigned fresh_id, stack_top;
   logic [7:0]  free_ids [NENT];
   bit          alive [NENT];
   int unsigned where [NTYP][NENT];
   logic [7:0]  owner [NTYP][NENT];
   logic [31:0] payload [NTYP][NENT];
   int unsigned members [NTYP];

   response_type pending [$];
   int errors = 0, rsp_seen = 0, idle_cycles = 0;
   bit hold_off = 0, lazy_rx = 1;

   function automatic bit has_member(int t, int e);
      int unsigned i;
      i = where[t][e];
      return i < members[t] && owner[t][i] == e;
   endfunction

   function automatic void swap_out(int t, int e);
      int unsigned i, last;
      i = where[t][e];
      last = members[t] - 1;
      if (i != last) begin
         owner[t][i] = owner[t][last];
         payload[t][i] = payload[t][last];
         where[t][owner[t][last]] = i;
      end
      members[t] = last;
   endfunction

   function automatic response_type apply_command(request_type r);
      response_type o;
      int e, t, n;
      e = r.entity;
      t = r.ctype;
      o = '0;
      o.entity = r.entity;
      if (r.cmd == ecss_pkg::CMD_CREATE) begin
         if (stack_top > 0) begin
            stack_top--;
            o.entity = free_ids[stack_top];
            alive[o.entity] = 1;
         end else if (fresh_id < NENT) begin
            o.entity = 8'(fresh_id);
            fresh_id++;
            alive[o.entity] = 1;
         end else begin
            o.status = ecss_pkg::ST_EXHAUSTED;
         end
      end else if (r.cmd > ecss_pkg::CMD_QUERY) begin
      end else if (!alive[e]) begin
         o.status = ecss_pkg::ST_BAD_ENT;
      end else if (r.cmd == ecss_pkg::CMD_DESTROY) begin
         alive[e] = 0;
         free_ids[stack_top] = 8'(e);
         stack_top++;
         for (int k = 0; k < NTYP; k++)
            if (members[k] > 0 && has_member(k, e)) swap_out(k, e);
      end else if (!enables[t]) begin
         o.status = ecss_pkg::ST_DISABLED;
      end else if (r.cmd == ecss_pkg::CMD_ATTACH) begin
         if (members[t] > 0 && has_member(t, e)) begin
            o.status = ecss_pkg::ST_DUPLICATE;
         end else begin
            n = members[t];
            where[t][e] = n;
            owner[t][n] = 8'(e);
            payload[t][n] = r.data;
            members[t] = n + 1;
         end
      end else if (r.cmd == ecss_pkg::CMD_DETACH) begin
         if (members[t] == 0) o.status = ecss_pkg::ST_OK;
         else if (!has_member(t, e)) o.status = ecss_pkg::ST_NOT_ATT;
         else swap_out(t, e);
      end else begin
         if (members[t] == 0 || !has_member(t, e)) o.status = ecss_pkg::ST_NOT_ATT;
         else o.data = payload[t][where[t][e]];
      end
      o.count = 9'(members[t]);
      return o;
   endfunction

   // Response checker and receiver stall pattern.
   always @(posedge clock) begin
      response_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[51:0];
         rsp_seen++;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected: %h", $time, got);
            errors++;
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.entity !== want.entity) begin
               $display("%0t: entity expected %0d actual %0d", $time, want.entity, got.entity);
               errors++;
            end
            if (got.data !== want.data) begin
               $display("%0t: data expected %h actual %h", $time, want.data, got.data);
               errors++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
               errors++;
            end
         end
      end
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= lazy_rx ? ($urandom_range(99) >= 27) : 1'b1;
   end

   // Watchdog on cycles without any accepted transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("** entity_component_sparse_sets: FAILED **");
         $finish;
      end
   end

   // The request stays valid after acceptance until a gap or a drain drops it,
   // so back-to-back requests simply replace the data.
   task automatic send_request(request_type r, bit gaps);
      while (gaps && $urandom_range(99) < 27) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b0, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending.push_back(apply_command(r));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_enables(logic [3:0] mask);
      drain();
      csr_valid <= 1;
      csr_data <= mask;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      enables = mask;
      for (int k = 0; k < NTYP; k++) members[k] = 0;
   endtask

   function automatic request_type random_request(bit valid_ids);
      request_type r;
      int p;
      r.data = $urandom;
      r.ctype = 2'($urandom_range(3));
      p = $urandom_range(99);
      r.cmd = p < 15 ? ecss_pkg::CMD_CREATE : p < 25 ? ecss_pkg::CMD_DESTROY :
              p < 55 ? ecss_pkg::CMD_ATTACH : p < 70 ? ecss_pkg::CMD_DETACH :
              p < 97 ? ecss_pkg::CMD_QUERY : 3'($urandom_range(5, 7));
      r.entity = valid_ids ? 8'($urandom_range(fresh_id > 0 ? fresh_id - 1 : 0))
                           : 8'($urandom);
      return r;
   endfunction

   directed_row_type rows [$];

   function automatic void add_row(logic [2:0] c, logic [7:0] e, logic [1:0] t,
                                   logic [31:0] d, bit typed, response_type x);
      directed_row_type w;
      w.cmd = c; w.entity = e; w.ctype = t; w.data = d; w.typed = typed; w.rsp = x;
      rows.push_back(w);
   endfunction

   initial begin
      request_type r;
      response_type x;
      logic [3:0] masks [6];
      enables = 0; fresh_id = 0; stack_top = 0;
      for (int k = 0; k < NTYP; k++) members[k] = 0;
      for (int i = 0; i < NENT; i++) alive[i] = 0;
      masks = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h7, 4'hF};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: all types disabled after reset, then after enabling all.
      add_row(ecss_pkg::CMD_QUERY, 8'd0, 2'd0, '0, 1, '{0, 0, 8'd0, ecss_pkg::ST_BAD_ENT});
      add_row(ecss_pkg::CMD_CREATE, 8'd99, 2'd0, '0, 1, '{0, 0, 8'd0, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_ATTACH, 8'd0, 2'd3, 32'hFFFFFFFF, 1,
              '{0, 0, 8'd0, ecss_pkg::ST_DISABLED});
      add_row(ecss_pkg::CMD_DESTROY, 8'd255, 2'd0, '0, 1,
              '{0, 0, 8'd255, ecss_pkg::ST_BAD_ENT});
      // An unknown command code changes nothing and reports ok.
      add_row(3'd7, 8'd0, 2'd1, 32'h5, 1, '{0, 0, 8'd0, ecss_pkg::ST_OK});
      foreach (rows[i]) begin
         r = '{rows[i].data, rows[i].ctype, rows[i].entity, rows[i].cmd};
         send_request(r, 0);
         if (rows[i].typed) pending[$] = rows[i].rsp;
      end
      rows.delete();
      write_enables(4'hF);
      add_row(ecss_pkg::CMD_ATTACH, 8'd0, 2'd3, 32'hFFFFFFFF, 1,
              '{1, 0, 8'd0, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_ATTACH, 8'd0, 2'd3, 32'h1, 1,
              '{1, 0, 8'd0, ecss_pkg::ST_DUPLICATE});
      add_row(ecss_pkg::CMD_QUERY, 8'd0, 2'd3, '0, 1,
              '{1, 32'hFFFFFFFF, 8'd0, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_CREATE, 8'd0, 2'd0, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_ATTACH, 8'd1, 2'd3, 32'h0, 1, '{2, 0, 8'd1, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_QUERY, 8'd1, 2'd2, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_NOT_ATT});
      add_row(ecss_pkg::CMD_DETACH, 8'd1, 2'd2, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_DETACH, 8'd0, 2'd3, '0, 0, '0);
      add_row(ecss_pkg::CMD_DETACH, 8'd0, 2'd3, '0, 1, '{1, 0, 8'd0, ecss_pkg::ST_NOT_ATT});
      add_row(ecss_pkg::CMD_QUERY, 8'd1, 2'd3, '0, 0, '0);
      add_row(ecss_pkg::CMD_DESTROY, 8'd1, 2'd3, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_OK});
      add_row(ecss_pkg::CMD_DESTROY, 8'd1, 2'd3, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_BAD_ENT});
      add_row(ecss_pkg::CMD_CREATE, 8'd200, 2'd0, '0, 1, '{0, 0, 8'd1, ecss_pkg::ST_OK});
      foreach (rows[i]) begin
         r = '{rows[i].data, rows[i].ctype, rows[i].entity, rows[i].cmd};
         send_request(r, 0);
         if (rows[i].typed) pending[$] = rows[i].rsp;
      end

      // Exhaust the pool, attach each id, then destroy random ids.
      for (int i = 0; i < 256; i++)
         send_request('{$urandom, 2'd0, 8'd0, ecss_pkg::CMD_CREATE}, 1);
      for (int i = 0; i < 256; i++)
         send_request('{$urandom, 2'($urandom), 8'(i), ecss_pkg::CMD_ATTACH}, 1);
      for (int i = 0; i < 256; i++)
         send_request('{32'h0, 2'($urandom), 8'($urandom), ecss_pkg::CMD_DESTROY}, 1);

      // Receiver holds off while the sender keeps offering.
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 20; i++) send_request(random_request(1), 0);
      join
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_enables(masks[ph]);
         lazy_rx = (ph != 3);
         for (int i = 0; i < 135; i++)
            send_request(random_request($urandom_range(9) != 0), lazy_rx);
      end
      drain();

      $display("Covered %0d responses: allocation to pool exhaustion, free-list reuse,", rsp_seen);
      $display("attach/detach/query/destroy across six type-enable masks with stalls.");
      if (errors == 0) begin
         $display("** entity_component_sparse_sets: PASSED **");
      end else begin
         $display("** entity_component_sparse_sets: FAILED **");
      end
      $finish;
   end
endmodule

// File: entity_component_sparse_sets.f
hdl/ecss_pkg.sv
hdl/ecss_ram.sv
hdl/ecss_ctrl.sv
hdl/ecss_dpath.sv
hdl/entity_component_sparse_sets.sv
bench/entity_component_sparse_sets_test.sv
